@@ src/rbs_pkg.sv @@
// Shared types, constants and helpers for the ray/box slab intersection block.
// Used by rbs_div, rbs_hit and the top level ray_box_slab_intersection.
package rbs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUOT_BITS     = 33;
    localparam int DIV_LAT       = QUOT_BITS + 2;
    localparam int HIT_LAT       = 3;
    localparam int SAT_W         = 66;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        FACE_NX = 3'd0,
        FACE_PX = 3'd1,
        FACE_NY = 3'd2,
        FACE_PY = 3'd3,
        FACE_NZ = 3'd4,
        FACE_PZ = 3'd5
    } t_face;

    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5,
        CFG_TOL   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic             mode;
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [31:0]      tlo;
        logic [31:0]      thi;
        logic [2:0]       zero;
        logic             miss;
    } t_ray;

    typedef struct packed {
        logic        hit;
        logic        two;
        logic [31:0] enter;
        logic [31:0] leave;
    } t_hinfo;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_W'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < SAT_W'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/rbs_div.sv @@
// Pipelined restoring divider: saturated signed quotient (diff * 2^F) / den.
// One quotient bit per stage; depends on rbs_pkg.
module rbs_div
    import rbs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_diff,
    input  logic signed [31:0] i_den,
    output logic signed [31:0] o_quot
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = 32 + QUOT_BITS;

    logic [NW-1:0]        r_rem [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] r_q   [0:QUOT_BITS];
    logic [31:0]          r_den [0:QUOT_BITS];
    logic                 r_neg [0:QUOT_BITS];
    logic                 r_ovf [0:QUOT_BITS];

    logic [32:0] n_mag;
    logic [31:0] n_dmag;

    always_comb begin
        n_mag  = i_diff[32] ? 33'(-i_diff) : 33'(i_diff);
        n_dmag = i_den[31] ? 32'(-i_den) : 32'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {n_mag, {FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
            r_den[0] <= n_dmag;
            r_neg[0] <= i_diff[32] ^ i_den[31];
            r_ovf[0] <= (n_mag >> (33 - FRAC_BITS)) >= {1'b0, n_dmag};
        end
    end

    for (genvar s = 1; s <= QUOT_BITS; s++) begin : g_stage
        logic [CW-1:0] w_sh;
        logic [CW-1:0] w_rem;
        always_comb begin
            w_sh  = CW'(r_den[s-1]) << (QUOT_BITS - s);
            w_rem = CW'(r_rem[s-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= r_den[s-1];
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
                if (w_rem >= w_sh) begin
                    r_rem[s] <= NW'(w_rem - w_sh);
                    r_q[s]   <= r_q[s-1] | (QUOT_BITS'(1) << (QUOT_BITS - s));
                end else begin
                    r_rem[s] <= r_rem[s-1];
                    r_q[s]   <= r_q[s-1];
                end
            end
        end
    end

    logic [QUOT_BITS-1:0]   w_q;
    logic signed [31:0]     n_quot;
    logic signed [31:0]     r_quot;
    localparam logic [QUOT_BITS-1:0] LIM = QUOT_BITS'(1) << 31;

    always_comb begin
        w_q = r_q[QUOT_BITS];
        if (r_ovf[QUOT_BITS]) begin
            n_quot = r_neg[QUOT_BITS] ? S32_MIN : S32_MAX;
        end else if (!r_neg[QUOT_BITS]) begin
            n_quot = (w_q >= LIM) ? S32_MAX : $signed(w_q[31:0]);
        end else begin
            n_quot = (w_q > LIM) ? S32_MIN : $signed(-w_q[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

@@ src/rbs_hit.sv @@
// Hit point and face code for one ray distance, three register stages:
// multiply, shift and saturate, face compare. Depends on rbs_pkg.
module rbs_hit
    import rbs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [31:0]      i_t,
    input  logic [2:0][31:0] i_org,
    input  logic [2:0][31:0] i_dir,
    input  logic [2:0][31:0] i_box_min,
    input  logic [2:0][31:0] i_box_max,
    input  logic [15:0]      i_tol,
    output logic [2:0][31:0] o_pt,
    output logic [2:0]       o_face
);

    logic [2:0][63:0] r_prod;
    logic [2:0][31:0] r_org;
    logic [2:0][31:0] r_pt;
    logic [2:0][31:0] r_pt_f;
    logic [2:0]       r_face;
    logic [2:0][31:0] n_pt;
    logic [2:0]       n_face;
    logic [5:0]       w_on;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= $signed(i_dir[k]) * $signed(i_t);
            end
            r_org <= i_org;
        end
    end

    always_comb begin
        logic signed [63:0]      q;
        logic signed [SAT_W-1:0] s;
        for (int k = 0; k < 3; k++) begin
            q        = $signed(r_prod[k]) >>> FRAC_BITS;
            s        = $signed({{(SAT_W-32){r_org[k][31]}}, r_org[k]})
                     + $signed({{(SAT_W-64){q[63]}}, q});
            n_pt[k]  = sat32(s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt <= n_pt;
        end
    end

    always_comb begin
        logic signed [32:0] dmin;
        logic signed [32:0] dmax;
        logic [32:0]        amin;
        logic [32:0]        amax;
        for (int k = 0; k < 3; k++) begin
            dmin = $signed({r_pt[k][31], r_pt[k]}) - $signed({i_box_min[k][31], i_box_min[k]});
            dmax = $signed({r_pt[k][31], r_pt[k]}) - $signed({i_box_max[k][31], i_box_max[k]});
            amin = dmin[32] ? 33'(-dmin) : 33'(dmin);
            amax = dmax[32] ? 33'(-dmax) : 33'(dmax);
            w_on[2*k]   = amin <= {17'b0, i_tol};
            w_on[2*k+1] = amax <= {17'b0, i_tol};
        end
        if (w_on[0]) begin
            n_face = FACE_NX;
        end else if (w_on[1]) begin
            n_face = FACE_PX;
        end else if (w_on[2]) begin
            n_face = FACE_NY;
        end else if (w_on[3]) begin
            n_face = FACE_PY;
        end else if (w_on[4]) begin
            n_face = FACE_NZ;
        end else begin
            n_face = FACE_PZ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt_f <= r_pt;
            r_face <= n_face;
        end
    end

    assign o_pt   = r_pt_f;
    assign o_face = r_face;

endmodule

@@ src/ray_box_slab_intersection.sv @@
// Top level of the ray versus axis-aligned box slab intersection block.
// Uses rbs_pkg, rbs_div (six slab dividers) and rbs_hit (entry and exit points).
//
// A ray request enters every cycle unless o_stall is high; it passes through
// one input register, 35 stages of the pipelined slab dividers, three stages of
// slab ordering, entry/exit selection and window test, three stages of hit point
// and face, and one output register. A ray that yields two results holds the
// output register while both are shown, and no new ray enters until the second
// result is taken; every other ray leaves after one accepted result. A stall
// while the output holds a result freezes the whole pipeline.
module ray_box_slab_intersection
    import rbs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_origin_z,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_dir_z,
    input  logic [31:0] i_t_low,
    input  logic [31:0] i_t_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_hit,
    output logic [31:0] o_hit_t,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [31:0] o_point_z,
    output logic [2:0]  o_face,
    output logic        o_last
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic [2:0][31:0] r_box_min;
    logic [2:0][31:0] r_box_max;
    logic [15:0]      r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min <= {3{-ONE}};
            r_box_max <= {3{ONE}};
            r_tol     <= 16'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_X: r_box_min[0] <= i_cfg_data;
                CFG_MIN_Y: r_box_min[1] <= i_cfg_data;
                CFG_MIN_Z: r_box_min[2] <= i_cfg_data;
                CFG_MAX_X: r_box_max[0] <= i_cfg_data;
                CFG_MAX_Y: r_box_max[1] <= i_cfg_data;
                CFG_MAX_Z: r_box_max[2] <= i_cfg_data;
                CFG_TOL:   r_tol        <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    logic w_en;
    logic w_out_acc;

    // Input register.
    logic r1_v;
    t_ray r1;
    t_ray n1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1.mode <= i_mode;
            r1.org  <= {i_origin_z, i_origin_y, i_origin_x};
            r1.dir  <= {i_dir_z, i_dir_y, i_dir_x};
            r1.tlo  <= i_t_low;
            r1.thi  <= i_t_high;
            r1.zero <= '0;
            r1.miss <= 1'b0;
        end
    end

    // Slab dividers and the matching delay line of ray data.
    logic signed [31:0] w_q_lo [0:2];
    logic signed [31:0] w_q_hi [0:2];

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [32:0] w_dlo;
        logic signed [32:0] w_dhi;
        assign w_dlo = $signed({r_box_min[k][31], r_box_min[k]})
                     - $signed({r1.org[k][31], r1.org[k]});
        assign w_dhi = $signed({r_box_max[k][31], r_box_max[k]})
                     - $signed({r1.org[k][31], r1.org[k]});
        rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_diff (w_dlo),
            .i_den  ($signed(r1.dir[k])),
            .o_quot (w_q_lo[k])
        );
        rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_diff (w_dhi),
            .i_den  ($signed(r1.dir[k])),
            .o_quot (w_q_hi[k])
        );
    end

    always_comb begin
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        n1 = r1;
        for (int k = 0; k < 3; k++) begin
            if ($signed(r_box_min[k]) < $signed(r_box_max[k])) begin
                mn = $signed(r_box_min[k]);
                mx = $signed(r_box_max[k]);
            end else begin
                mn = $signed(r_box_max[k]);
                mx = $signed(r_box_min[k]);
            end
            n1.zero[k] = (r1.dir[k] == 32'd0);
            if (n1.zero[k] && (($signed(r1.org[k]) < mn) || ($signed(r1.org[k]) > mx))) begin
                n1.miss = 1'b1;
            end
        end
    end

    t_ray r_dl  [0:DIV_LAT-1];
    logic r_dlv [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) begin
                r_dlv[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_dlv[0] <= r1_v;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_dlv[s] <= r_dlv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= n1;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_dl[s] <= r_dl[s-1];
            end
        end
    end

    // Per-axis near and far distances.
    logic               r_o_v;
    t_ray               r_o;
    logic signed [31:0] r_tn [0:2];
    logic signed [31:0] r_tf [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= r_dlv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o <= r_dl[DIV_LAT-1];
            for (int k = 0; k < 3; k++) begin
                if (r_dl[DIV_LAT-1].zero[k]) begin
                    r_tn[k] <= S32_MIN;
                    r_tf[k] <= S32_MAX;
                end else if (w_q_lo[k] < w_q_hi[k]) begin
                    r_tn[k] <= w_q_lo[k];
                    r_tf[k] <= w_q_hi[k];
                end else begin
                    r_tn[k] <= w_q_hi[k];
                    r_tf[k] <= w_q_lo[k];
                end
            end
        end
    end

    // Entry and exit.
    logic               r_x_v;
    t_ray               r_x;
    t_ray               n_x;
    logic signed [31:0] r_enter;
    logic signed [31:0] r_leave;
    logic signed [31:0] n_enter;
    logic signed [31:0] n_leave;

    always_comb begin
        n_enter = r_tn[0];
        n_leave = r_tf[0];
        for (int k = 1; k < 3; k++) begin
            if (r_tn[k] > n_enter) begin
                n_enter = r_tn[k];
            end
            if (r_tf[k] < n_leave) begin
                n_leave = r_tf[k];
            end
        end
        n_x      = r_o;
        n_x.miss = r_o.miss || (n_enter > n_leave);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (w_en) begin
            r_x_v <= r_o_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x      <= n_x;
            r_enter  <= n_enter;
            r_leave  <= n_leave;
        end
    end

    // Window test.
    logic   r_w_v;
    t_ray   r_w;
    t_hinfo r_wi;
    t_hinfo n_wi;

    always_comb begin
        logic near_in;
        logic far_in;
        near_in = (r_enter > $signed(r_x.tlo)) && (r_enter < $signed(r_x.thi));
        far_in  = (r_leave > $signed(r_x.tlo)) && (r_leave < $signed(r_x.thi));
        n_wi.enter = r_enter;
        n_wi.leave = r_leave;
        if (!r_x.mode) begin
            n_wi.hit = !r_x.miss && (r_enter >= $signed(r_x.tlo))
                     && (r_enter <= $signed(r_x.thi));
            n_wi.two = 1'b0;
        end else begin
            n_wi.hit = !r_x.miss && (near_in || far_in);
            n_wi.two = !r_x.miss && far_in && (r_leave != r_enter);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
        end else if (w_en) begin
            r_w_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w  <= r_x;
            r_wi <= n_wi;
        end
    end

    // Hit points and faces for entry and exit.
    logic [2:0][31:0] w_pt0;
    logic [2:0][31:0] w_pt1;
    logic [2:0]       w_face0;
    logic [2:0]       w_face1;

    rbs_hit #(.FRAC_BITS(FRAC_BITS)) u_hit_enter (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_t       (r_wi.enter),
        .i_org     (r_w.org),
        .i_dir     (r_w.dir),
        .i_box_min (r_box_min),
        .i_box_max (r_box_max),
        .i_tol     (r_tol),
        .o_pt      (w_pt0),
        .o_face    (w_face0)
    );

    rbs_hit #(.FRAC_BITS(FRAC_BITS)) u_hit_leave (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_t       (r_wi.leave),
        .i_org     (r_w.org),
        .i_dir     (r_w.dir),
        .i_box_min (r_box_min),
        .i_box_max (r_box_max),
        .i_tol     (r_tol),
        .o_pt      (w_pt1),
        .o_face    (w_face1)
    );

    t_hinfo r_hd  [0:HIT_LAT-1];
    logic   r_hdv [0:HIT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < HIT_LAT; s++) begin
                r_hdv[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_hdv[0] <= r_w_v;
            for (int s = 1; s < HIT_LAT; s++) begin
                r_hdv[s] <= r_hdv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hd[0] <= r_wi;
            for (int s = 1; s < HIT_LAT; s++) begin
                r_hd[s] <= r_hd[s-1];
            end
        end
    end

    // Output register; a two-result ray is shown in two steps.
    logic             r_ov;
    logic             r_sel;
    logic             r_two;
    logic             r_hit;
    logic [31:0]      r_t0;
    logic [31:0]      r_t1;
    logic [2:0][31:0] r_p0;
    logic [2:0][31:0] r_p1;
    logic [2:0]       r_f0;
    logic [2:0]       r_f1;
    t_hinfo           w_hl;

    assign w_hl      = r_hd[HIT_LAT-1];
    assign w_out_acc = r_ov && !i_stall;
    assign w_en      = !r_ov || (w_out_acc && (!r_two || r_sel));
    assign o_stall   = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_sel <= 1'b0;
        end else if (w_en) begin
            r_ov  <= r_hdv[HIT_LAT-1];
            r_sel <= 1'b0;
        end else if (w_out_acc) begin
            r_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= w_hl.hit;
            r_two <= w_hl.two;
            if (w_hl.hit) begin
                r_t0 <= w_hl.enter;
                r_t1 <= w_hl.leave;
                r_p0 <= w_pt0;
                r_p1 <= w_pt1;
                r_f0 <= w_face0;
                r_f1 <= w_face1;
            end else begin
                r_t0 <= '0;
                r_t1 <= '0;
                r_p0 <= '0;
                r_p1 <= '0;
                r_f0 <= '0;
                r_f1 <= '0;
            end
        end
    end

    assign o_valid   = r_ov;
    assign o_is_hit  = r_hit;
    assign o_hit_t   = r_sel ? r_t1 : r_t0;
    assign o_point_x = r_sel ? r_p1[0] : r_p0[0];
    assign o_point_y = r_sel ? r_p1[1] : r_p0[1];
    assign o_point_z = r_sel ? r_p1[2] : r_p0[2];
    assign o_face    = r_sel ? r_f1 : r_f0;
    assign o_last    = !r_two || r_sel;

endmodule

@@ test/tb_ray_box_slab_intersection.sv @@
// Self-checking testbench for ray_box_slab_intersection: slab entry/exit, window rules,
// hit points and face codes, checked against an in-bench fixed-point predictor.
// Depends on rbs_pkg and the ray_box_slab_intersection top level.
`timescale 1ns / 100ps

module tb_ray_box_slab_intersection;
    import rbs_pkg::*;

    localparam int FB = 16;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    typedef struct packed {
        logic        is_hit;
        logic [31:0] t;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [2:0]  face;
        logic        last;
    } t_hit_res;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_mode = 0;
    logic [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [31:0] i_t_low = '0, i_t_high = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic        o_is_hit;
    logic [31:0] o_hit_t, o_point_x, o_point_y, o_point_z;
    logic [2:0]  o_face;
    logic        o_last;

    ray_box_slab_intersection dut (.*);

    longint bmin[3], bmax[3], tol;
    t_hit_res hits_due[$];
    int n_err = 0;
    int stall_pct = 0;

    initial forever #1 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint sat(longint v);
        if (v > MAXV) return MAXV;
        if (v < MINV) return MINV;
        return v;
    endfunction

    function automatic longint point_on(longint o, longint d, longint t);
        longint p, q;
        p = d * t;
        q = p / (64'sd1 <<< FB);
        if (p < 0 && (p % (64'sd1 <<< FB)) != 0) q -= 1;
        return sat(o + q);
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void queue_hit(t_hit_res h);
        hits_due = {hits_due, h};
    endfunction

    function automatic t_hit_res make_hit(longint o[3], longint d[3], longint t, bit lst);
        t_hit_res r;
        longint p[3];
        for (int k = 0; k < 3; k++) p[k] = point_on(o[k], d[k], t);
        r.is_hit = 1;
        r.t = t[31:0];
        r.px = p[0][31:0];
        r.py = p[1][31:0];
        r.pz = p[2][31:0];
        if (labs(p[0] - bmin[0]) <= tol) r.face = FACE_NX;
        else if (labs(p[0] - bmax[0]) <= tol) r.face = FACE_PX;
        else if (labs(p[1] - bmin[1]) <= tol) r.face = FACE_NY;
        else if (labs(p[1] - bmax[1]) <= tol) r.face = FACE_PY;
        else if (labs(p[2] - bmin[2]) <= tol) r.face = FACE_NZ;
        else r.face = FACE_PZ;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_hits(bit md, logic [31:0] org[3], logic [31:0] dr[3],
                                logic [31:0] tl, logic [31:0] th);
        longint o[3], d[3], a, b, tn, tf, ent, lev, lo, hi;
        bit missed, nin, fin;
        t_hit_res m;
        missed = 0;
        ent = MINV;
        lev = MAXV;
        for (int k = 0; k < 3; k++) begin
            o[k] = longint'($signed(org[k]));
            d[k] = longint'($signed(dr[k]));
            if (d[k] == 0) begin
                if (o[k] < (bmin[k] < bmax[k] ? bmin[k] : bmax[k]) ||
                    o[k] > (bmin[k] < bmax[k] ? bmax[k] : bmin[k])) missed = 1;
                tn = MINV;
                tf = MAXV;
            end else begin
                a = sat(((bmin[k] - o[k]) * (64'sd1 <<< FB)) / d[k]);
                b = sat(((bmax[k] - o[k]) * (64'sd1 <<< FB)) / d[k]);
                tn = a < b ? a : b;
                tf = a < b ? b : a;
            end
            if (tn > ent) ent = tn;
            if (tf < lev) lev = tf;
        end
        lo = longint'($signed(tl));
        hi = longint'($signed(th));
        if (!missed && ent > lev) missed = 1;
        if (!missed) begin
            if (md == 0) begin
                missed = ent < lo || ent > hi;
                if (!missed) queue_hit(make_hit(o, d, ent, 1));
            end else begin
                nin = ent > lo && ent < hi;
                fin = lev > lo && lev < hi;
                missed = !nin && !fin;
                if (!missed && fin && lev != ent) begin
                    queue_hit(make_hit(o, d, ent, 0));
                    queue_hit(make_hit(o, d, lev, 1));
                end else if (!missed) begin
                    queue_hit(make_hit(o, d, ent, 1));
                end
            end
        end
        if (missed) begin
            m = '0;
            m.last = 1;
            queue_hit(m);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        t_hit_res w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hits_due.size() == 0) begin
                report_mismatch("unexpected result", o_hit_t, 0);
            end else begin
                w = hits_due.pop_front();
                if (o_is_hit !== w.is_hit)
                    report_mismatch("is_hit", 32'(o_is_hit), 32'(w.is_hit));
                if (o_hit_t !== w.t) report_mismatch("hit_t", o_hit_t, w.t);
                if (o_point_x !== w.px) report_mismatch("point_x", o_point_x, w.px);
                if (o_point_y !== w.py) report_mismatch("point_y", o_point_y, w.py);
                if (o_point_z !== w.pz) report_mismatch("point_z", o_point_z, w.pz);
                if (o_face !== w.face) report_mismatch("face", 32'(o_face), 32'(w.face));
                if (o_last !== w.last) report_mismatch("last", 32'(o_last), 32'(w.last));
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_MIN_X: bmin[0] = longint'($signed(val));
            CFG_MIN_Y: bmin[1] = longint'($signed(val));
            CFG_MIN_Z: bmin[2] = longint'($signed(val));
            CFG_MAX_X: bmax[0] = longint'($signed(val));
            CFG_MAX_Y: bmax[1] = longint'($signed(val));
            CFG_MAX_Z: bmax[2] = longint'($signed(val));
            default: tol = longint'(val[15:0]);
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_box(logic [31:0] mn[3], logic [31:0] mx[3], logic [15:0] tl);
        write_reg(CFG_MIN_X, mn[0]);
        write_reg(CFG_MIN_Y, mn[1]);
        write_reg(CFG_MIN_Z, mn[2]);
        write_reg(CFG_MAX_X, mx[0]);
        write_reg(CFG_MAX_Y, mx[1]);
        write_reg(CFG_MAX_Z, mx[2]);
        write_reg(CFG_TOL, {16'h0, tl});
    endtask

    // Holds a request until accepted; the next request or a gap follows at the edge.
    task automatic send_ray(bit md, logic [31:0] org[3], logic [31:0] dr[3],
                            logic [31:0] tl, logic [31:0] th);
        i_valid <= 1;
        i_mode <= md;
        i_origin_x <= org[0];
        i_origin_y <= org[1];
        i_origin_z <= org[2];
        i_dir_x <= dr[0];
        i_dir_y <= dr[1];
        i_dir_z <= dr[2];
        i_t_low <= tl;
        i_t_high <= th;
        predict_hits(md, org, dr, tl, th);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_gap(int n);
        i_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        idle_gap(1);
        while (hits_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (hits_due.size() != 0) begin
            report_mismatch("missing results", 32'(hits_due.size()), 0);
        end
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord(int span);
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h0;
            default: return 32'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] o[3], d[3];
        logic [31:0] ext[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        o = '{32'hFFFD_0000, 32'h0, 32'h0};
        d = '{32'h0001_0000, 32'h0, 32'h0};
        send_ray(0, o, d, 32'h0, 32'h7FFF_FFFF);
        send_ray(1, o, d, 32'h0, 32'h7FFF_FFFF);
        send_ray(1, o, d, 32'h0002_8000, 32'h0010_0000);
        send_ray(0, o, d, 32'h0010_0000, 32'h0020_0000);
        d = '{32'h0, 32'h0, 32'h0};
        send_ray(0, o, d, 32'h8000_0000, 32'h7FFF_FFFF);
        o = '{32'h0, 32'h0, 32'h0};
        send_ray(1, o, d, 32'h8000_0000, 32'h7FFF_FFFF);
        send_ray(0, o, d, 32'h8000_0000, 32'h7FFF_FFFF);
        d = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000};
        send_ray(1, o, d, 32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) begin
            o = '{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]};
            d = '{ext[(i + 3) % 4], ext[i], ext[(i + 1) % 4]};
            send_ray(i[0], o, d, ext[i], ext[(i + 1) % 4]);
        end
        o = '{32'h0001_0000, 32'h0, 32'h0};
        d = '{32'h0, 32'h0001_0000, 32'h0};
        send_ray(0, o, d, 32'h8000_0000, 32'h7FFF_FFFF);
        send_ray(1, o, d, 32'h0, 32'h0);
        drain();
    endtask

    task automatic test_random(int count, int span, int pct);
        logic [31:0] o[3], d[3], tl, th;
        int burst;
        stall_pct = pct;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 3; k++) begin
                o[k] = rnd_coord(span);
                d[k] = ($urandom_range(7) == 0) ? 32'h0 : rnd_coord(span);
            end
            if ($urandom_range(3) == 0) begin
                tl = $urandom();
                th = $urandom();
            end else begin
                tl = 32'($signed($urandom_range(4 * 65536)) - 3 * 65536);
                th = tl + $urandom_range(16 * 65536);
            end
            send_ray(1'($urandom_range(1)), o, d, tl, th);
            if (burst == 0) begin
                burst = $urandom_range(30);
                if ($urandom_range(2) == 0) idle_gap($urandom_range(1, 6));
            end else begin
                burst--;
            end
        end
        drain();
    endtask

    task automatic test_box_settings();
        logic [31:0] mn[3], mx[3];
        mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        mx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        set_box(mn, mx, 16'hFFFF);
        test_random(300, 32'h4000_0000, 30);
        mn = '{32'h0002_0000, 32'hFFFF_8000, 32'h0003_0000};
        mx = '{32'hFFFE_0000, 32'h0000_8000, 32'h0};
        set_box(mn, mx, 16'h0);
        test_random(300, 4 * 65536, 0);
        mn = '{32'h0, 32'h0, 32'h0};
        mx = '{32'h0, 32'h0, 32'h0};
        set_box(mn, mx, 16'h0100);
        test_random(200, 2 * 65536, 60);
        mn = '{32'hFFFC_0000, 32'hFFFE_0000, 32'hFFFF_0000};
        mx = '{32'h0004_0000, 32'h0002_0000, 32'h0001_0000};
        set_box(mn, mx, 16'h0040);
        test_random(500, 6 * 65536, 20);
    endtask

    initial begin
        bmin = '{-65536, -65536, -65536};
        bmax = '{65536, 65536, 65536};
        tol = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random(600, 4 * 65536, 15);
        test_box_settings();
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
